>>> rtl/core/tagged_entry_kth_select_top_defines.svh
// Assertion macros shared by the tagged entry k-th select block.
// Standalone header; the including file supplies clock, reset and the expressions.
`ifndef TAGGED_ENTRY_KTH_SELECT_TOP_DEFINES_SVH
`define TAGGED_ENTRY_KTH_SELECT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEKS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("teks assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TEKS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("teks assertion failed");

`endif

>>> rtl/core/teks_pkg.sv
// Shared constants, opcodes and control/status structs of the k-th select block.
// No dependencies; ctrl, datapath and top use scoped names, the bench imports it.
`default_nettype none

package teks_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES     = 4096;
  localparam int SOLVED_CAPACITY = 4096;
  localparam int ENTRY_AW        = $clog2(MAX_ENTRIES);
  localparam int SOLVED_AW       = $clog2(SOLVED_CAPACITY);

  // Field widths.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 12;
  localparam int RAW_W   = 16;
  localparam int RANK_W  = 12;
  localparam int TAG_W   = 2;
  localparam int COUNT_W = 13;
  localparam int NUM_TAGS = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Stream payload widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TAG  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 4'd1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic dispatch;
    logic load;
    logic scan;
    logic probe;
    logic settle;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            clr_done;
    logic [OP_W-1:0] op;
    logic            rank_miss;
    logic            cache_hit;
    logic            scan_hit;
    logic            scan_miss;
    logic            out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/teks_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; contents are not reset.
`default_nettype none

module teks_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/teks_ctrl.sv
// Controller state machine of the k-th select block.
// Depends on teks_pkg for the command and status structs and the opcodes.
`default_nettype none

module teks_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire teks_pkg::status_t status_i,
  output teks_pkg::cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_SCAN,
    ST_SOLVE,
    ST_SETTLE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  // Next state and commands for the current state.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture = in_valid_i & ready_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        case (status_i.op)
          teks_pkg::OP_LOAD: begin
            state_d = ST_LOAD;
          end
          teks_pkg::OP_LOOKUP, teks_pkg::OP_MARK: begin
            if (status_i.rank_miss) begin
              state_d = ST_RESULT;
            end else if (status_i.cache_hit) begin
              state_d = ST_SOLVE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          default: begin
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = ST_RESULT;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_hit) begin
          state_d = ST_SOLVE;
        end else if (status_i.scan_miss) begin
          state_d = ST_RESULT;
        end
      end
      ST_SOLVE: begin
        cmd_o.probe = 1'b1;
        state_d = ST_SETTLE;
      end
      ST_SETTLE: begin
        cmd_o.settle = 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register and the registered input ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

>>> rtl/core/teks_dp.sv
// Datapath of the k-th select block: tag and solved memories, counts, cache, scan
// pointers and the output register. Depends on teks_pkg and teks_ram.
`default_nettype none

module teks_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Captured input fields.
  input  wire logic [teks_pkg::OP_W-1:0]         op_i,
  input  wire logic [teks_pkg::IDX_W-1:0]        entry_index_i,
  input  wire logic [teks_pkg::RAW_W-1:0]        raw_tag_i,
  input  wire logic [teks_pkg::RANK_W-1:0]       rank_in_tag_i,
  // Configuration writes.
  input  wire logic                              cfg_we_i,
  input  wire logic [teks_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [teks_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Result register.
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   found_o,
  output logic [teks_pkg::IDX_W-1:0]             match_index_o,
  output logic                                   solved_flag_o,
  output logic [teks_pkg::COUNT_W-1:0]           tag_total_o,
  // Controller link.
  input  wire teks_pkg::cmd_t                    cmd_i,
  output teks_pkg::status_t                      status_o
);

  localparam int CNT_W = teks_pkg::COUNT_W;
  localparam int IW    = teks_pkg::IDX_W;

  // Captured operation.
  logic [teks_pkg::OP_W-1:0]   op_q;
  logic [IW-1:0]               idx_q;
  logic [teks_pkg::RAW_W-1:0]  raw_q;
  logic [teks_pkg::RANK_W-1:0] rank_q;

  // Configuration, counts and cache.
  logic [teks_pkg::TAG_W-1:0]  active_tag_q;
  logic [CNT_W-1:0]            entry_count_q;
  logic [CNT_W-1:0]            count_q [teks_pkg::NUM_TAGS];
  logic                        cache_valid_q;
  logic [teks_pkg::RANK_W-1:0] cache_rank_q;
  logic [IW-1:0]               cache_pos_q;

  // Scan state and per-operation result.
  logic [CNT_W-1:0]            ptr_q;
  logic [CNT_W-1:0]            matched_q;
  logic                        rv_q;
  logic [IW-1:0]               rpos_q;
  logic                        res_found_q;
  logic [IW-1:0]               res_pos_q;
  logic                        res_solved_q;
  logic                        rd_pend_q;
  logic [teks_pkg::SOLVED_AW-1:0] clr_addr_q;

  // Output register.
  logic                        out_valid_q;
  logic                        out_found_q;
  logic [IW-1:0]               out_pos_q;
  logic                        out_solved_q;
  logic [CNT_W-1:0]            out_total_q;

  logic [teks_pkg::TAG_W-1:0]  load_tag;
  logic [teks_pkg::TAG_W-1:0]  tag_rdata;
  logic                        solved_rdata;
  logic [CNT_W-1:0]            active_count;
  logic [CNT_W-1:0]            limit;
  logic                        issue;
  logic                        match;
  logic                        scan_hit;
  logic                        rank_ahead;
  logic                        in_range;
  logic                        mark_wr;
  logic                        solved_we;
  logic [teks_pkg::SOLVED_AW-1:0] solved_waddr;
  logic                        solved_re;

  // Raw tags above the last category fold to category zero.
  assign load_tag = (raw_q > teks_pkg::RAW_W'(teks_pkg::NUM_TAGS - 1)) ? '0
                                                                        : raw_q[teks_pkg::TAG_W-1:0];

  assign active_count = count_q[active_tag_q];
  assign limit = (entry_count_q > CNT_W'(teks_pkg::MAX_ENTRIES)) ?
                 CNT_W'(teks_pkg::MAX_ENTRIES) : entry_count_q;
  assign rank_ahead = cache_valid_q && (rank_q > cache_rank_q);

  // Scan compare on the data that returns in the cycle after each read.
  assign issue    = ptr_q < limit;
  assign match    = rv_q && (tag_rdata == active_tag_q);
  assign scan_hit = match && (matched_q == {1'b0, rank_q});

  // The solved bit exists only below the capacity and below the entry count.
  assign in_range = ({1'b0, res_pos_q} < CNT_W'(teks_pkg::SOLVED_CAPACITY)) &&
                    ({1'b0, res_pos_q} < entry_count_q);
  assign mark_wr  = cmd_i.probe && in_range && (op_q == teks_pkg::OP_MARK);

  assign solved_we    = cmd_i.clear | mark_wr;
  assign solved_waddr = cmd_i.clear ? clr_addr_q : teks_pkg::SOLVED_AW'(res_pos_q);
  assign solved_re    = cmd_i.probe && in_range && (op_q == teks_pkg::OP_LOOKUP);

  // Status toward the controller.
  always_comb begin
    status_o.clr_done  = (clr_addr_q == teks_pkg::SOLVED_AW'(teks_pkg::SOLVED_CAPACITY - 1));
    status_o.op        = op_q;
    status_o.rank_miss = ({1'b0, rank_q} >= active_count);
    status_o.cache_hit = cache_valid_q && (rank_q == cache_rank_q);
    status_o.scan_hit  = scan_hit;
    status_o.scan_miss = !rv_q && !issue;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  teks_ram #(
    .WIDTH (teks_pkg::TAG_W),
    .DEPTH (teks_pkg::MAX_ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (teks_pkg::ENTRY_AW'(idx_q)),
    .wdata_i (load_tag),
    .re_i    (cmd_i.scan & issue),
    .raddr_i (ptr_q[teks_pkg::ENTRY_AW-1:0]),
    .rdata_o (tag_rdata)
  );

  teks_ram #(
    .WIDTH (1),
    .DEPTH (teks_pkg::SOLVED_CAPACITY)
  ) u_solved_ram (
    .clk_i   (clk_i),
    .we_i    (solved_we),
    .waddr_i (solved_waddr),
    .wdata_i (!cmd_i.clear),
    .re_i    (solved_re),
    .raddr_i (teks_pkg::SOLVED_AW'(res_pos_q)),
    .rdata_o (solved_rdata)
  );

  // Input capture registers hold payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      idx_q  <= entry_index_i;
      raw_q  <= raw_tag_i;
      rank_q <= rank_in_tag_i;
    end
  end

  // Configuration, counts, cache, scan and result control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_tag_q  <= '0;
      entry_count_q <= '0;
      for (int i = 0; i < teks_pkg::NUM_TAGS; i++) begin
        count_q[i] <= '0;
      end
      cache_valid_q <= 1'b0;
      cache_rank_q  <= '0;
      cache_pos_q   <= '0;
      ptr_q         <= '0;
      matched_q     <= '0;
      rv_q          <= 1'b0;
      rpos_q        <= '0;
      res_found_q   <= 1'b0;
      res_pos_q     <= '0;
      res_solved_q  <= 1'b0;
      rd_pend_q     <= 1'b0;
      clr_addr_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // Register writes; a new active tag drops the cached hit.
      if (cfg_we_i) begin
        case (cfg_index_i)
          teks_pkg::CFG_ACTIVE_TAG: begin
            active_tag_q  <= cfg_data_i[teks_pkg::TAG_W-1:0];
            cache_valid_q <= 1'b0;
            cache_rank_q  <= '0;
            cache_pos_q   <= '0;
          end
          teks_pkg::CFG_ENTRY_COUNT: begin
            entry_count_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end

      // Clearing pass over the solved bits after reset.
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end

      // A new operation starts with an empty result.
      if (cmd_i.capture) begin
        res_found_q  <= 1'b0;
        res_pos_q    <= '0;
        res_solved_q <= 1'b0;
      end

      // Saturating count of the loaded tag.
      if (cmd_i.load && (count_q[load_tag] != teks_pkg::COUNT_MAX)) begin
        count_q[load_tag] <= count_q[load_tag] + 1'b1;
      end

      // Answer a lookup or mark from the cache, or set up the scan start point.
      if (cmd_i.dispatch) begin
        if (status_o.cache_hit && !status_o.rank_miss &&
            ((op_q == teks_pkg::OP_LOOKUP) || (op_q == teks_pkg::OP_MARK))) begin
          res_found_q <= 1'b1;
          res_pos_q   <= cache_pos_q;
        end
        if (rank_ahead) begin
          ptr_q     <= {1'b0, cache_pos_q} + 1'b1;
          matched_q <= {1'b0, cache_rank_q} + 1'b1;
        end else begin
          ptr_q     <= '0;
          matched_q <= '0;
        end
      end

      // One table read issued and one compared per cycle.
      rv_q <= cmd_i.scan & issue;
      if (cmd_i.scan) begin
        if (issue) begin
          ptr_q  <= ptr_q + 1'b1;
          rpos_q <= ptr_q[IW-1:0];
        end
        if (scan_hit) begin
          res_found_q   <= 1'b1;
          res_pos_q     <= rpos_q;
          cache_valid_q <= 1'b1;
          cache_rank_q  <= rank_q;
          cache_pos_q   <= rpos_q;
        end else if (match) begin
          matched_q <= matched_q + 1'b1;
        end
      end

      // Solved bit of the located entry.
      rd_pend_q <= solved_re;
      if (mark_wr) begin
        res_solved_q <= 1'b1;
      end
      if (cmd_i.settle && rd_pend_q) begin
        res_solved_q <= solved_rdata;
      end

      // Result register valid.
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
      out_solved_q <= res_solved_q;
      out_total_q  <= active_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign match_index_o = out_pos_q;
  assign solved_flag_o = out_solved_q;
  assign tag_total_o   = out_total_q;

endmodule

`default_nettype wire

>>> rtl/core/tagged_entry_kth_select_top.sv
// Usage: items arrive on the s_axis channel with the opcode in tuser; one result per
// item leaves on the m_axis channel with the found flag in tuser. Registers are
// written on the cfg channel (index 0 active tag, index 1 entry count), which is
// always ready; write them only while no transaction is in flight.
// After reset the solved bitmap is cleared, one entry per cycle, over all 4096 entries;
// s_axis_tready stays low during that pass.
// One item is worked on at a time. After acceptance the controller dispatches it:
// the unused opcode or a rank not below the tag count goes straight to the result
// state, a load writes the tag memory first, and a lookup or mark answered from
// the last-hit cache first probes and settles the solved bit. A lookup or mark
// that misses the cache scans the tag memory at one entry per cycle from the
// start, or from just after the cached hit for a larger rank, over at most 4096
// entries; a hit then probes and settles the solved bit, a miss goes to the result.
// s_axis_tready rises together with m_axis_tvalid, so the next item can be
// accepted while that result is on offer.
// The output register holds its result while m_axis_tready is low; the next item
// may be accepted then, but its result waits until the held one is taken.
// Depends on teks_pkg, teks_ctrl, teks_dp, teks_ram and the assertion header.
`default_nettype none

`include "tagged_entry_kth_select_top_defines.svh"

module tagged_entry_kth_select_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input items.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: entry_index[11:0], raw_tag[27:12], rank_in_tag[39:28].
  input  wire logic [teks_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: opcode[1:0].
  input  wire logic [teks_pkg::OP_W-1:0]           s_axis_tuser,
  // Result items.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: match_index[11:0], solved_flag[12], tag_total[25:13], zero[31:26].
  output logic [teks_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // tuser: found[0].
  output logic                                     m_axis_tuser,
  // Configuration writes.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [teks_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [teks_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  teks_pkg::cmd_t    cmd;
  teks_pkg::status_t status;

  logic [teks_pkg::IDX_W-1:0]   match_index;
  logic                         solved_flag;
  logic [teks_pkg::COUNT_W-1:0] tag_total;

  assign cfg_ready_o = 1'b1;

  teks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  teks_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (s_axis_tuser),
    .entry_index_i  (s_axis_tdata[11:0]),
    .raw_tag_i      (s_axis_tdata[27:12]),
    .rank_in_tag_i  (s_axis_tdata[39:28]),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .found_o        (m_axis_tuser),
    .match_index_o  (match_index),
    .solved_flag_o  (solved_flag),
    .tag_total_o    (tag_total),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign m_axis_tdata = {6'd0, tag_total, solved_flag, match_index};

  // An accepted transaction closes the input until its result is out.
  `TEKS_ASSERT_NEXT(a_accept_closes, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A solved flag is only reported for an entry that was found.
  `TEKS_ASSERT_NOW(a_solved_needs_found, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[12], m_axis_tuser)

  // A result without a located entry reports index zero.
  `TEKS_ASSERT_NOW(a_miss_index_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[11:0] == 12'd0)

endmodule

`default_nettype wire

>>> tb/sv/tb_tagged_entry_kth_select_top.sv
// Self-checking testbench for tagged_entry_kth_select_top: streams tag loads, k-th lookups
// and solve marks, and checks every answer against an in-bench model of the tag table.
// Depends on teks_pkg and the block's RTL only.
`default_nettype none

module tb_tagged_entry_kth_select_top;
  import teks_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 4'd15;
  localparam int MAX_GAP       = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_PHASES    = 7;
  // Clearing pass plus 200 commands that each scan the whole table and wait out both
  // sides' longest idle, taken four times over.
  localparam int CYCLE_LIMIT = 4 * (MAX_ENTRIES + 200 * (MAX_ENTRIES + 16 + 2 * MAX_GAP));

  // Bit positions of the answer fields in m_axis_tdata.
  localparam int SOLVED_BIT = IDX_W;
  localparam int TOTAL_LSB  = IDX_W + 1;
  localparam int TOTAL_MSB  = IDX_W + COUNT_W;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  entry_index;
    logic [RAW_W-1:0]  raw_tag;
    logic [RANK_W-1:0] rank;
  } command_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   match_index;
    logic               solved;
    logic [COUNT_W-1:0] tag_total;
  } answer_t;

  // Clock, reset and the block's ports.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  s_valid   = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic [OP_W-1:0]       s_user    = '0;
  logic                  m_valid;
  logic                  m_ready   = 1'b1;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_user;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Model of the block's state; two-state so that everything starts at its reset value.
  bit [TAG_W-1:0]      tag_mem      [MAX_ENTRIES];
  bit                  entry_loaded [MAX_ENTRIES];
  bit                  solved_map   [SOLVED_CAPACITY];
  bit [COUNT_W-1:0]    tag_count    [NUM_TAGS];
  bit                  hit_valid;
  bit [RANK_W-1:0]     hit_rank;
  bit [IDX_W-1:0]      hit_pos;
  bit [TAG_W-1:0]      sel_tag;
  bit [CFG_DATA_W-1:0] table_span;

  command_t    command_queue [$];
  answer_t     answer_queue  [$];
  command_t    cur_command;
  int unsigned commands_sent;
  int unsigned commands_taken;
  int unsigned commands_retired;
  int unsigned answers_taken;
  int unsigned answers_paced;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned fill_next;
  int          fail_count;
  int          feed_gap;
  bit          feed_armed;
  int          stall_left;
  bit          steady;

  // Table layout for the directed part: tag 1 sits at entries 0, 2, 4, 7, 9 and 11.
  logic [RAW_W-1:0] seed_tags [12] = '{16'd1, 16'd0, 16'd1, 16'd2, 16'd1, 16'd3,
                                       16'hFFFF, 16'd1, 16'd4, 16'd1, 16'd2, 16'd1};

  // Random phases: active tag write (negative skips it), entry count, length, no idling.
  int phase_tag    [NUM_PHASES] = '{2, 0, 8191, 1, -1, 0, -1};
  int phase_span   [NUM_PHASES] = '{40, 8191, 4096, 0, 20, 64, 5};
  int phase_len    [NUM_PHASES] = '{16, 16, 16, 12, 16, 20, 18};
  bit phase_steady [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  tagged_entry_kth_select_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  // Finds the entry of the given rank among those carrying the active tag, without
  // touching the cache. Clean is cleared if the scan would read a never-loaded entry.
  function automatic void locate_rank(input bit [RANK_W-1:0] rank, output bit hit,
                                      output bit [IDX_W-1:0] pos, output bit clean);
    int unsigned p;
    int unsigned seen;
    int unsigned lim;
    hit   = 1'b0;
    pos   = '0;
    clean = 1'b1;
    p     = 0;
    seen  = 0;
    lim   = (table_span < MAX_ENTRIES) ? table_span : MAX_ENTRIES;
    if (rank >= tag_count[sel_tag]) return;
    if (hit_valid) begin
      if (rank == hit_rank) begin
        hit = 1'b1;
        pos = hit_pos;
        return;
      end
      if (rank > hit_rank) begin
        p    = hit_pos + 1;
        seen = hit_rank + 1;
      end
    end
    while (p < lim) begin
      if (!entry_loaded[p]) clean = 1'b0;
      if (tag_mem[p] == sel_tag) begin
        if (seen == rank) begin
          hit = 1'b1;
          pos = IDX_W'(p);
          return;
        end
        seen++;
      end
      p++;
    end
  endfunction

  // Register write as the block sees it.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_ACTIVE_TAG) begin
      sel_tag   = val[TAG_W-1:0];
      hit_valid = 1'b0;
      hit_rank  = '0;
      hit_pos   = '0;
    end else if (idx == CFG_ENTRY_COUNT) begin
      table_span = val;
    end
  endfunction

  // Updates the model for one accepted command and queues the answer it must produce.
  function automatic void apply_command(input command_t cmd);
    answer_t        ans;
    bit             hit;
    bit             clean;
    bit [IDX_W-1:0] pos;
    bit [TAG_W-1:0] tag;
    ans = '0;
    case (cmd.op)
      OP_LOAD: begin
        tag = (cmd.raw_tag > 3) ? '0 : cmd.raw_tag[TAG_W-1:0];
        tag_mem[cmd.entry_index]      = tag;
        entry_loaded[cmd.entry_index] = 1'b1;
        if (tag_count[tag] != COUNT_MAX) tag_count[tag]++;
      end
      OP_LOOKUP, OP_MARK: begin
        locate_rank(cmd.rank, hit, pos, clean);
        if (hit) begin
          hit_valid       = 1'b1;
          hit_rank        = cmd.rank;
          hit_pos         = pos;
          ans.found       = 1'b1;
          ans.match_index = pos;
          if (pos < SOLVED_CAPACITY && pos < table_span) begin
            if (cmd.op == OP_MARK) solved_map[pos] = 1'b1;
            ans.solved = solved_map[pos];
          end
        end
      end
      default: ;
    endcase
    ans.tag_total = tag_count[sel_tag];
    answer_queue.push_back(ans);
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Samples every handshake at the rising edge and keeps the model in step.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        reg_writes++;
      end
      if (m_valid && m_ready) begin
        if (answer_queue.size() == 0) begin
          $error("result transaction arrived with no answer expected");
          fail_count++;
        end else begin
          want = answer_queue.pop_front();
          compare_field("found", want.found, m_user);
          compare_field("match_index", want.match_index, m_data[IDX_W-1:0]);
          compare_field("solved_flag", want.solved, m_data[SOLVED_BIT]);
          compare_field("tag_total", want.tag_total, m_data[TOTAL_MSB:TOTAL_LSB]);
          compare_field("padding", 0, m_data[OUT_DATA_W-1:TOTAL_MSB+1]);
        end
        answers_taken++;
      end
      if (s_valid && s_ready) begin
        apply_command(cur_command);
        commands_taken++;
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Command driver: retires the accepted command, then presents the next one after a
  // random gap.
  always @(negedge clk) begin
    logic next_valid;
    next_valid = s_valid;
    if (rst_n) begin
      if (s_valid && commands_taken != commands_retired) begin
        commands_retired = commands_taken;
        next_valid       = 1'b0;
      end
      if (!next_valid && command_queue.size() != 0) begin
        if (!feed_armed) begin
          feed_gap   = steady ? 0 : $urandom_range(0, MAX_GAP);
          feed_armed = 1'b1;
        end
        if (feed_gap == 0) begin
          cur_command = command_queue.pop_front();
          feed_armed  = 1'b0;
          next_valid  = 1'b1;
          s_data <= {cur_command.rank, cur_command.raw_tag, cur_command.entry_index};
          s_user <= cur_command.op;
        end else begin
          feed_gap--;
        end
      end
    end
    s_valid <= next_valid;
  end

  // Result back-pressure: each answer is held for a random number of valid cycles.
  always @(negedge clk) begin
    if (answers_taken != answers_paced) begin
      answers_paced = answers_taken;
      stall_left    = steady ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (stall_left > 0) begin
      if (m_valid) stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    int unsigned target;
    target = reg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (reg_writes == target);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hands one command to the driver and waits until the block has taken it, so that
  // the next command is drawn against an up-to-date model.
  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [RAW_W-1:0] raw, input logic [RANK_W-1:0] rank);
    command_t cmd;
    cmd.op          = op;
    cmd.entry_index = idx;
    cmd.raw_tag     = raw;
    cmd.rank        = rank;
    command_queue.push_back(cmd);
    commands_sent++;
    wait (commands_taken == commands_sent);
  endtask

  task automatic drain();
    wait (answer_queue.size() == 0);
  endtask

  // Mostly loads that grow the table from the bottom and lookups at reachable ranks;
  // the rest are stray loads, far ranks and the unused opcode. A rank whose scan would
  // read a never-loaded entry is pushed to the tag count so that no scan happens.
  task automatic issue_random();
    int unsigned     pick;
    int unsigned     total;
    logic [OP_W-1:0] op;
    bit [IDX_W-1:0]  idx;
    bit [RAW_W-1:0]  raw;
    bit [RANK_W-1:0] rank;
    bit [IDX_W-1:0]  pos;
    bit              hit;
    bit              clean;
    idx   = IDX_W'($urandom);
    raw   = RAW_W'($urandom);
    rank  = RANK_W'($urandom);
    total = tag_count[sel_tag];
    pick  = $urandom_range(0, 99);
    if (pick < 10) begin
      op = OP_SPARE;
    end else if (pick < 40) begin
      op   = OP_LOAD;
      pick = $urandom_range(0, 99);
      if (pick < 70 && fill_next < MAX_ENTRIES) begin
        idx = IDX_W'(fill_next);
        fill_next++;
      end else if (pick < 90) begin
        idx = IDX_W'($urandom_range(0, fill_next - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) raw = RAW_W'(sel_tag);
      else if (pick < 75) raw = RAW_W'($urandom_range(0, 3));
      else if (pick < 90) raw = RAW_W'($urandom_range(4, 65535));
    end else begin
      op   = (pick < 70) ? OP_LOOKUP : OP_MARK;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Keep the full-range rank.
      end else if (hit_valid && pick < 35) begin
        rank = hit_rank;
      end else if (hit_valid && pick < 55) begin
        rank = RANK_W'(hit_rank + $urandom_range(1, 3));
      end else if (total != 0) begin
        rank = RANK_W'($urandom_range(0, total - 1));
      end else begin
        rank = '0;
      end
      locate_rank(rank, hit, pos, clean);
      if (!clean) rank = RANK_W'(total);
    end
    issue(op, idx, raw, rank);
  endtask

  initial begin
    int p;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: a rank with no tagged entries, then the unused opcode with all ones.
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd0);
    issue(OP_SPARE, '1, '1, '1);
    drain();
    write_register(CFG_ACTIVE_TAG, 13'd1);
    write_register(CFG_ENTRY_COUNT, 13'd12);

    // Known layout, raw tags above 3 among them, plus the top entry outside the span.
    for (int i = 0; i < 12; i++) issue(OP_LOAD, IDX_W'(i), seed_tags[i], RANK_W'($urandom));
    issue(OP_LOAD, 12'hFFF, 16'd3, RANK_W'($urandom));
    fill_next = 12;

    // Fresh scan, cache hit, resume past the hit, restart for a smaller rank.
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd2);
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd2);
    issue(OP_MARK, IDX_W'($urandom), RAW_W'($urandom), 12'd4);
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd1);
    issue(OP_MARK, IDX_W'($urandom), RAW_W'($urandom), 12'd5);
    // Ranks at and far above the tag count.
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd6);
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'hFFF);
    // Reloading the cached entry keeps the cache; the stale hit is still answered.
    issue(OP_LOAD, 12'd11, 16'd2, RANK_W'($urandom));
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd5);
    // Counts now exceed the matching entries, so this scan runs off the span.
    issue(OP_LOAD, 12'd2, 16'd0, RANK_W'($urandom));
    issue(OP_LOOKUP, IDX_W'($urandom), RAW_W'($urandom), 12'd4);

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 1) begin
        write_register(CFG_SPARE_LOW, '1);
        write_register(CFG_SPARE_HIGH, '0);
      end
      write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(phase_span[p]));
      if (phase_tag[p] >= 0) write_register(CFG_ACTIVE_TAG, CFG_DATA_W'(phase_tag[p]));
      steady = phase_steady[p];
      repeat (phase_len[p]) issue_random();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> tagged_entry_kth_select_top.f
+incdir+rtl/core
rtl/core/teks_pkg.sv
rtl/core/teks_ram.sv
rtl/core/teks_ctrl.sv
rtl/core/teks_dp.sv
rtl/core/tagged_entry_kth_select_top.sv
tb/sv/tb_tagged_entry_kth_select_top.sv
